@@ src/peer_presence_table_assert.svh @@
// Assertion macros for the peer presence table.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef PEER_PRESENCE_TABLE_ASSERT_SVH
`define PEER_PRESENCE_TABLE_ASSERT_SVH

// Check a condition on every clock edge outside reset.
`define PPT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define PPT_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ src/ppt_pkg.sv @@
// Shared types, constants and the control store for the peer presence table.
// No dependencies; imported by ppt_div, peer_presence_table and the bench.
package ppt_pkg;

  localparam int ENTRIES    = 16;
  localparam int ENTRY_W    = $clog2(ENTRIES);
  localparam int MASK_N     = (ENTRIES < 16) ? ENTRIES : 16;
  localparam int RES_IDX_W  = 4;

  localparam int KEY_W      = 32;
  localparam int AGE_W      = 16;
  localparam int GAIN_W     = 9;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int WORD_W     = KEY_W + AGE_W + GAIN_W;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;

  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  // scale by 1/100: multiply by ceil(2^31 / 100), keep bits from 31 up;
  // exact for magnitudes below 2^25
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 31;
  localparam int QUO_W       = PROD_W + RECIP_W - RECIP_SHIFT;

  localparam logic [ENTRY_W-1:0]   LAST_IDX          = ENTRY_W'(ENTRIES - 1);
  localparam logic [GAIN_W-1:0]    DEFAULT_GAIN      = 9'd100;
  localparam logic [DIVISOR_W-1:0] PERCENT           = 16'd100;
  localparam logic [RECIP_W-1:0]   RECIP             = 25'd21474837;
  localparam logic [AGE_W-1:0]     TICK_STEP_RST     = 16'd1000;
  localparam logic [AGE_W-1:0]     OFFLINE_LIMIT_RST = 16'd3000;
  localparam logic [AGE_W-1:0]     AGE_MAX           = 16'hFFFF;
  localparam logic [15:0]          COUNT_MAX         = 16'hFFFF;
  localparam logic [15:0]          POS_MAX           = 16'd32767;
  localparam logic [15:0]          NEG_MAX           = 16'd32768;

  typedef enum logic [1:0] {
    CMD_PACKET = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_VOLUME = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ID        = 2'd0,
    REG_TICK_STEP     = 2'd1,
    REG_OFFLINE_LIMIT = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_OWN       = 3'd0,
    ST_REFRESHED = 3'd1,
    ST_ADDED     = 3'd2,
    ST_FULL      = 3'd3,
    ST_TICKED    = 3'd4,
    ST_VOL_SET   = 3'd5,
    ST_NOT_FOUND = 3'd6,
    ST_SAMPLE    = 3'd7
  } status_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_OWN,
    OP_READ,
    OP_CMP,
    OP_ALLOC,
    OP_FULL,
    OP_NOTFOUND,
    OP_REFRESH,
    OP_VOLUME,
    OP_MUL,
    OP_ABS,
    OP_RECIP,
    OP_SAT,
    OP_DIV_AVG,
    OP_AVG,
    OP_AGE,
    OP_TICKED,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_BEAT,
    C_IS_TICK,
    C_IS_OWN,
    C_SCAN_MORE,
    C_HIT,
    C_NOT_PKT,
    C_NO_FREE,
    C_IS_VOL,
    C_IS_SMP,
    C_TICK_MORE,
    C_DIV_BUSY,
    C_NOT_LAST,
    C_OUT_BUSY
  } cond_e;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t S_EMIT       = 5'd0;
  localparam pc_t S_FETCH      = 5'd1;
  localparam pc_t S_DISPATCH   = 5'd2;
  localparam pc_t S_OWN_CHK    = 5'd3;
  localparam pc_t S_FIND       = 5'd4;
  localparam pc_t S_FIND_CMP   = 5'd5;
  localparam pc_t S_HIT_CHK    = 5'd6;
  localparam pc_t S_PKT_CHK    = 5'd7;
  localparam pc_t S_FREE_CHK   = 5'd8;
  localparam pc_t S_ALLOC      = 5'd9;
  localparam pc_t S_FULL       = 5'd10;
  localparam pc_t S_MISS       = 5'd11;
  localparam pc_t S_FOUND      = 5'd12;
  localparam pc_t S_SMP_CHK    = 5'd13;
  localparam pc_t S_REFRESH    = 5'd14;
  localparam pc_t S_VOL        = 5'd15;
  localparam pc_t S_SMP        = 5'd16;
  localparam pc_t S_SCALE      = 5'd17;
  localparam pc_t S_RECIP      = 5'd18;
  localparam pc_t S_SAT        = 5'd19;
  localparam pc_t S_AVG_START  = 5'd20;
  localparam pc_t S_WAIT_AVG   = 5'd21;
  localparam pc_t S_AVG        = 5'd22;
  localparam pc_t S_TICK       = 5'd23;
  localparam pc_t S_AGE        = 5'd24;
  localparam pc_t S_TICK_DONE  = 5'd25;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [AGE_W-1:0]  age;
    logic [GAIN_W-1:0] gain;
  } entry_t;

  typedef struct packed {
    status_e              status;
    logic [RES_IDX_W-1:0] idx;
    logic [15:0]          scaled;
    logic [15:0]          avg;
    logic                 valid;
  } result_t;

  function automatic uword_t mk(op_e o, cond_e c, pc_t t);
    uword_t w;
    w.op     = o;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      S_EMIT:       w = mk(OP_EMIT,      C_OUT_BUSY,  S_EMIT);
      S_FETCH:      w = mk(OP_ACCEPT,    C_NO_BEAT,   S_FETCH);
      S_DISPATCH:   w = mk(OP_NOP,       C_IS_TICK,   S_TICK);
      S_OWN_CHK:    w = mk(OP_OWN,       C_IS_OWN,    S_EMIT);
      S_FIND:       w = mk(OP_READ,      C_NEVER,     S_FIND);
      S_FIND_CMP:   w = mk(OP_CMP,       C_SCAN_MORE, S_FIND);
      S_HIT_CHK:    w = mk(OP_NOP,       C_HIT,       S_FOUND);
      S_PKT_CHK:    w = mk(OP_NOP,       C_NOT_PKT,   S_MISS);
      S_FREE_CHK:   w = mk(OP_NOP,       C_NO_FREE,   S_FULL);
      S_ALLOC:      w = mk(OP_ALLOC,     C_ALWAYS,    S_EMIT);
      S_FULL:       w = mk(OP_FULL,      C_ALWAYS,    S_EMIT);
      S_MISS:       w = mk(OP_NOTFOUND,  C_ALWAYS,    S_EMIT);
      S_FOUND:      w = mk(OP_NOP,       C_IS_VOL,    S_VOL);
      S_SMP_CHK:    w = mk(OP_NOP,       C_IS_SMP,    S_SMP);
      S_REFRESH:    w = mk(OP_REFRESH,   C_ALWAYS,    S_EMIT);
      S_VOL:        w = mk(OP_VOLUME,    C_ALWAYS,    S_EMIT);
      S_SMP:        w = mk(OP_MUL,       C_NEVER,     S_SMP);
      S_SCALE:      w = mk(OP_ABS,       C_NEVER,     S_SCALE);
      S_RECIP:      w = mk(OP_RECIP,     C_NEVER,     S_RECIP);
      S_SAT:        w = mk(OP_SAT,       C_NOT_LAST,  S_EMIT);
      S_AVG_START:  w = mk(OP_DIV_AVG,   C_NEVER,     S_AVG_START);
      S_WAIT_AVG:   w = mk(OP_NOP,       C_DIV_BUSY,  S_WAIT_AVG);
      S_AVG:        w = mk(OP_AVG,       C_ALWAYS,    S_EMIT);
      S_TICK:       w = mk(OP_READ,      C_NEVER,     S_TICK);
      S_AGE:        w = mk(OP_AGE,       C_TICK_MORE, S_TICK);
      S_TICK_DONE:  w = mk(OP_TICKED,    C_ALWAYS,    S_EMIT);
      default:      w = mk(OP_NOP,       C_ALWAYS,    S_FETCH);
    endcase
    return w;
  endfunction

endpackage

@@ src/ppt_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ppt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/ppt_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ppt_pkg for operand widths.
module ppt_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ppt_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  logic [ppt_pkg::DIVISOR_W-1:0]   divisor_i,
  output logic                            busy_o,
  output logic [ppt_pkg::DIVIDEND_W-1:0]  quotient_o
);
  import ppt_pkg::*;

  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign busy_o = (cnt_q != '0);
  assign trial  = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff   = trial - {1'b0, dvs_q};
  assign fits   = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DIV_CNT_W'(DIVIDEND_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_o) begin
      rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient_o = quo_q;

endmodule

@@ src/peer_presence_table.sv @@
// Peer presence table: microcoded sequencer over a key/age/gain RAM, uses ppt_pkg,
// ppt_ram and ppt_div. One item at a time; the table is scanned one entry at a time,
// with a read state and then a compare state per entry. A tick ages every used entry;
// a last sample also waits for the divider to form the average amplitude.
// A result may wait in the output register while the output stalls.
// Reset: asynchronous, active low; clears presence bits, accumulators and control state.
`include "peer_presence_table_assert.svh"
module peer_presence_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ppt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppt_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // cmd[1:0], peer_id[33:2], volume[42:34], sample[58:43], zero fill
  input  logic [63:0]                   s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[2:0], entry_index[6:3], offline_mask[22:7], scaled_sample[38:23],
  // average_amplitude[54:39], zero fill
  output logic [55:0]                   m_axis_tdata,
  // amplitude_valid[0]
  output logic                          m_axis_tuser
);
  import ppt_pkg::*;

  logic [KEY_W-1:0]   own_id_q;
  logic [AGE_W-1:0]   tick_step_q;
  logic [AGE_W-1:0]   limit_q;

  pc_t                pc_q, pc_d;
  uword_t             uw;
  logic               cond_true;

  cmd_e               cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [GAIN_W-1:0]  vol_q;
  logic [SAMPLE_W-1:0] samp_q;
  logic               last_q;

  logic [ENTRY_W-1:0] idx_q, hit_idx_q, free_idx_q;
  logic               hit_q, free_q;
  logic [ENTRIES-1:0] used_q, offline_q;
  logic [31:0]        sum_q;
  logic [15:0]        count_q;

  result_t            res_q, out_q;
  logic [15:0]        out_mask_q;
  logic               out_valid_q;
  logic [15:0]        mask;

  entry_t             rd_entry, wr_entry;
  logic               ram_we, ram_re;
  logic [ENTRY_W-1:0] ram_waddr;

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic [PROD_W-1:0]        prod_abs, abs_q;
  logic                     neg_q;
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  logic [QUO_W-1:0]         scale_q;

  logic                     div_start, div_busy;
  logic [DIVIDEND_W-1:0]    div_dividend, div_quo;
  logic [DIVISOR_W-1:0]     div_divisor;

  logic               beat_in, out_busy, last_idx, hit_now;
  logic [AGE_W:0]     age_sum;
  logic [AGE_W-1:0]   new_age;
  logic [15:0]        sat_mag, sat_val;

  assign uw            = ucode(pc_q);
  assign s_axis_tready = (pc_q == S_FETCH);
  assign beat_in       = s_axis_tvalid && s_axis_tready;
  assign out_busy      = out_valid_q && !m_axis_tready;
  assign last_idx      = (idx_q == LAST_IDX);
  assign hit_now       = used_q[idx_q] && (rd_entry.key == key_q);

  always_comb begin
    unique case (uw.cond)
      C_NEVER:     cond_true = 1'b0;
      C_ALWAYS:    cond_true = 1'b1;
      C_NO_BEAT:   cond_true = !beat_in;
      C_IS_TICK:   cond_true = (cmd_q == CMD_TICK);
      C_IS_OWN:    cond_true = (cmd_q == CMD_PACKET) && (key_q == own_id_q);
      C_SCAN_MORE: cond_true = !hit_now && !last_idx;
      C_HIT:       cond_true = hit_q;
      C_NOT_PKT:   cond_true = (cmd_q != CMD_PACKET);
      C_NO_FREE:   cond_true = !free_q;
      C_IS_VOL:    cond_true = (cmd_q == CMD_VOLUME);
      C_IS_SMP:    cond_true = (cmd_q == CMD_SAMPLE);
      C_TICK_MORE: cond_true = !last_idx;
      C_DIV_BUSY:  cond_true = div_busy;
      C_NOT_LAST:  cond_true = !last_q;
      C_OUT_BUSY:  cond_true = out_busy;
      default:     cond_true = 1'b0;
    endcase
  end

  assign pc_d = cond_true ? uw.target : pc_t'(pc_q + 1'b1);

  assign age_sum  = {1'b0, rd_entry.age} + {1'b0, tick_step_q};
  assign new_age  = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];

  assign prod_d     = $signed(samp_q) * $signed({1'b0, rd_entry.gain});
  assign prod_abs   = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign recip_prod = abs_q * RECIP;

  always_comb begin
    if (neg_q) begin
      sat_mag = (scale_q > QUO_W'(NEG_MAX)) ? NEG_MAX : scale_q[15:0];
      sat_val = 16'(-sat_mag);
    end else begin
      sat_mag = (scale_q > QUO_W'(POS_MAX)) ? POS_MAX : scale_q[15:0];
      sat_val = sat_mag;
    end
  end

  always_comb begin
    mask = '0;
    for (int i = 0; i < MASK_N; i++) begin
      mask[i] = used_q[i] & offline_q[i];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_idx_q;
    wr_entry  = rd_entry;
    unique case (uw.op)
      OP_ALLOC: begin
        ram_we    = 1'b1;
        ram_waddr = free_idx_q;
        wr_entry  = '{key: key_q, age: '0, gain: DEFAULT_GAIN};
      end
      OP_REFRESH: begin
        ram_we       = 1'b1;
        wr_entry.age = '0;
      end
      OP_VOLUME: begin
        ram_we        = 1'b1;
        wr_entry.gain = vol_q;
      end
      OP_AGE: begin
        ram_we       = used_q[idx_q];
        ram_waddr    = idx_q;
        wr_entry.age = new_age;
      end
      default: ;
    endcase
  end

  assign ram_re       = (uw.op == OP_READ);
  assign div_start    = (uw.op == OP_DIV_AVG);
  assign div_dividend = sum_q;
  assign div_divisor  = count_q;

  ppt_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_entry),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(rd_entry)
  );

  ppt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .quotient_o(div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q    <= '0;
      tick_step_q <= TICK_STEP_RST;
      limit_q     <= OFFLINE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OWN_ID:        own_id_q    <= cfg_data_i;
        REG_TICK_STEP:     tick_step_q <= cfg_data_i[AGE_W-1:0];
        REG_OFFLINE_LIMIT: limit_q     <= cfg_data_i[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= S_FETCH;
      used_q      <= '0;
      offline_q   <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      unique case (uw.op)
        OP_ALLOC: begin
          used_q[free_idx_q]    <= 1'b1;
          offline_q[free_idx_q] <= 1'b0;
          sum_q                 <= '0;
          count_q               <= '0;
        end
        OP_REFRESH: begin
          offline_q[hit_idx_q] <= 1'b0;
          sum_q                <= '0;
          count_q              <= '0;
        end
        OP_AGE: begin
          if (used_q[idx_q] && (new_age > limit_q)) begin
            offline_q[idx_q] <= 1'b1;
          end
        end
        OP_SAT: begin
          if (count_q != COUNT_MAX) begin
            sum_q   <= sum_q + 32'(sat_mag);
            count_q <= count_q + 1'b1;
          end
        end
        OP_AVG: begin
          sum_q   <= '0;
          count_q <= '0;
        end
        default: ;
      endcase
      if ((uw.op == OP_EMIT) && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (uw.op)
      OP_ACCEPT: begin
        if (beat_in) begin
          cmd_q  <= cmd_e'(s_axis_tdata[1:0]);
          key_q  <= s_axis_tdata[33:2];
          vol_q  <= s_axis_tdata[42:34];
          samp_q <= s_axis_tdata[58:43];
          last_q <= s_axis_tlast;
          idx_q  <= '0;
          hit_q  <= 1'b0;
          free_q <= 1'b0;
          res_q  <= '{status: ST_OWN, idx: '0, scaled: '0, avg: '0, valid: 1'b0};
        end
      end
      OP_OWN:      res_q.status <= ST_OWN;
      OP_CMP: begin
        if (hit_now) begin
          hit_q     <= 1'b1;
          hit_idx_q <= idx_q;
        end
        if (!used_q[idx_q] && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= idx_q;
        end
        idx_q <= ENTRY_W'(idx_q + 1'b1);
      end
      OP_ALLOC: begin
        res_q.status <= ST_ADDED;
        res_q.idx    <= RES_IDX_W'(free_idx_q);
      end
      OP_FULL:     res_q.status <= ST_FULL;
      OP_NOTFOUND: res_q.status <= ST_NOT_FOUND;
      OP_REFRESH: begin
        res_q.status <= ST_REFRESHED;
        res_q.idx    <= RES_IDX_W'(hit_idx_q);
      end
      OP_VOLUME: begin
        res_q.status <= ST_VOL_SET;
        res_q.idx    <= RES_IDX_W'(hit_idx_q);
      end
      OP_MUL:      prod_q <= prod_d;
      OP_ABS: begin
        abs_q <= prod_abs;
        neg_q <= prod_q[PROD_W-1];
      end
      OP_RECIP:    scale_q <= recip_prod[PROD_W+RECIP_W-1:RECIP_SHIFT];
      OP_SAT: begin
        res_q.status <= ST_SAMPLE;
        res_q.idx    <= RES_IDX_W'(hit_idx_q);
        res_q.scaled <= sat_val;
      end
      OP_AVG: begin
        res_q.avg   <= div_quo[15:0];
        res_q.valid <= 1'b1;
      end
      OP_AGE:      idx_q <= ENTRY_W'(idx_q + 1'b1);
      OP_TICKED:   res_q.status <= ST_TICKED;
      OP_EMIT: begin
        if (!out_busy) begin
          out_q      <= res_q;
          out_mask_q <= mask;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.avg, out_q.scaled, out_mask_q, out_q.idx, out_q.status};
  assign m_axis_tuser  = out_q.valid;

  `PPT_ASSERT_IMPL(a_div_only_waiting, div_busy, pc_q == S_WAIT_AVG, "divider runs early")
  `PPT_ASSERT_IMPL(a_empty_sum, count_q == '0, sum_q == '0, "sum nonzero with no samples")
  `PPT_ASSERT_IMPL(a_avg_on_sample, m_axis_tvalid && m_axis_tuser, m_axis_tdata[2:0] == ST_SAMPLE, "average off sample")

endmodule

@@ bench/tb_peer_presence_table.sv @@
`timescale 1ns / 100ps
// Self-checking bench for peer_presence_table: streams packet, tick, volume and sample beats,
// predicts each result from a local copy of the table and compares it field by field.
// Depends on ppt_pkg and the peer_presence_table RTL only.
module tb_peer_presence_table;
  import ppt_pkg::*;

  localparam int POOL_N      = 18;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 120;

  typedef struct {
    cmd_e        cmd;
    logic [31:0] peer_id;
    logic [8:0]  volume;
    logic [15:0] sample;
    logic        last_sample;
  } peer_cmd_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  idx;
    logic [15:0] offline_mask;
    logic [15:0] scaled;
    logic [15:0] avg;
    logic        amp_valid;
  } table_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [55:0]          m_axis_tdata;
  logic                 m_axis_tuser;

  peer_cmd_t     queued_commands[$];
  table_result_t awaited_results[$];
  logic [31:0]   id_pool[POOL_N];
  int            snd_idle_pct = 0;
  int            rcv_idle_pct = 0;
  int            mismatches   = 0;
  int            results_seen = 0;
  int            hold_left    = 0;

  // local copy of the table
  logic [31:0] peer_key[ENTRIES];
  logic        peer_used[ENTRIES];
  logic        peer_offline[ENTRIES];
  logic [15:0] peer_age[ENTRIES];
  logic [8:0]  peer_gain[ENTRIES];
  logic [31:0] amp_sum;
  logic [15:0] amp_count;
  logic [31:0] own_id_q        = '0;
  logic [15:0] tick_step_q     = TICK_STEP_RST;
  logic [15:0] offline_limit_q = OFFLINE_LIMIT_RST;

  peer_presence_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic int find_peer(logic [31:0] id);
    int hit;
    hit = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (hit < 0 && peer_used[i] && peer_key[i] == id) hit = i;
    return hit;
  endfunction

  function automatic table_result_t peer_table_result(peer_cmd_t c);
    table_result_t r;
    int            hit;
    int            s_val;
    int            prod;
    int            mag;
    logic [16:0]   aged;
    r        = '0;
    r.status = ST_OWN;
    hit      = find_peer(c.peer_id);
    case (c.cmd)
      CMD_PACKET: begin
        if (c.peer_id != own_id_q) begin
          if (hit >= 0) begin
            r.status = ST_REFRESHED;
          end else begin
            for (int i = 0; i < ENTRIES; i++)
              if (hit < 0 && !peer_used[i]) hit = i;
            if (hit >= 0) begin
              peer_used[hit] = 1'b1;
              peer_key[hit]  = c.peer_id;
              peer_gain[hit] = DEFAULT_GAIN;
              r.status       = ST_ADDED;
            end else begin
              r.status = ST_FULL;
            end
          end
          if (hit >= 0) begin
            peer_offline[hit] = 1'b0;
            peer_age[hit]     = '0;
            amp_sum           = '0;
            amp_count         = '0;
            r.idx             = hit[3:0];
          end
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (peer_used[i]) begin
            aged        = {1'b0, peer_age[i]} + {1'b0, tick_step_q};
            peer_age[i] = aged[16] ? AGE_MAX : aged[15:0];
            if (peer_age[i] > offline_limit_q) peer_offline[i] = 1'b1;
          end
        end
        r.status = ST_TICKED;
      end
      CMD_VOLUME: begin
        if (hit >= 0) begin
          peer_gain[hit] = c.volume;
          r.status       = ST_VOL_SET;
          r.idx          = hit[3:0];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          s_val = int'($signed(c.sample));
          prod  = s_val * int'(peer_gain[hit]) / int'(PERCENT);
          if (prod > 32767) prod = 32767;
          if (prod < -32768) prod = -32768;
          mag = (prod < 0) ? -prod : prod;
          if (amp_count < COUNT_MAX) begin
            amp_sum   = amp_sum + mag;
            amp_count = amp_count + 16'd1;
          end
          if (c.last_sample) begin
            r.avg       = (amp_count != 0) ? 16'(amp_sum / amp_count) : 16'd0;
            r.amp_valid = 1'b1;
            amp_sum     = '0;
            amp_count   = '0;
          end
          r.scaled = prod[15:0];
          r.status = ST_SAMPLE;
          r.idx    = hit[3:0];
        end
      end
    endcase
    for (int i = 0; i < ENTRIES && i < 16; i++)
      r.offline_mask[i] = peer_used[i] && peer_offline[i];
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send(cmd_e c, logic [31:0] id, logic [8:0] vol, logic [15:0] smp, logic lst);
    peer_cmd_t item;
    item.cmd         = c;
    item.peer_id     = id;
    item.volume      = vol;
    item.sample      = smp;
    item.last_sample = lst;
    queued_commands.insert(queued_commands.size(), item);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_OWN_ID:    own_id_q = value;
      REG_TICK_STEP: tick_step_q = value[15:0];
      default:       offline_limit_q = value[15:0];
    endcase
  endtask

  task automatic drain();
    while (queued_commands.size() != 0 || awaited_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_peer();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 6) return own_id_q;
    if (roll < 14) return $urandom();
    return id_pool[$urandom_range(POOL_N - 1)];
  endfunction

  // mostly packet-then-samples bursts, with ticks, volume changes and noise mixed in
  task automatic queue_random(int n);
    int          left;
    int          roll;
    int          burst;
    logic [31:0] id;
    left = n;
    while (left > 0) begin
      roll = $urandom_range(99);
      id   = pick_peer();
      if (roll < 45) begin
        burst = $urandom_range(1, 6);
        if ($urandom_range(9) != 0)
          send(CMD_PACKET, id, 9'($urandom()), 16'($urandom()), 1'($urandom()));
        for (int j = 1; j <= burst; j++)
          send(CMD_SAMPLE, id, 9'($urandom()), 16'($urandom()),
               j == burst && $urandom_range(9) != 0);
        left -= burst + 1;
      end else if (roll < 55) begin
        send(CMD_TICK, $urandom(), 9'($urandom()), 16'($urandom()), 1'($urandom()));
        left--;
      end else if (roll < 70) begin
        send(CMD_VOLUME, id, 9'($urandom_range(0, roll < 65 ? 400 : 511)),
             16'($urandom()), 1'($urandom()));
        left--;
      end else if (roll < 82) begin
        send(CMD_PACKET, id, 9'($urandom()), 16'($urandom()), 1'($urandom()));
        left--;
      end else begin
        send(cmd_e'($urandom_range(3)), id, 9'($urandom()), 16'($urandom()),
             1'($urandom()));
        left--;
      end
    end
  endtask

  // driver: advance on acceptance, predict the accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (s_axis_tvalid)
        awaited_results.insert(awaited_results.size(),
                               peer_table_result(queued_commands.pop_front()));
      if (queued_commands.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, queued_commands[0].sample, queued_commands[0].volume,
                          queued_commands[0].peer_id, queued_commands[0].cmd};
        s_axis_tlast  <= queued_commands[0].last_sample;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: check each result beat, stall at random, hold off now and then
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (results_seen % 500 == 200) hold_left = HOLD_CYCLES;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h/%b", $time,
                   m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", 32'(want.status), 32'(m_axis_tdata[2:0]));
          compare_field("entry_index", 32'(want.idx), 32'(m_axis_tdata[6:3]));
          compare_field("offline_mask", 32'(want.offline_mask), 32'(m_axis_tdata[22:7]));
          compare_field("scaled_sample", 32'(want.scaled), 32'(m_axis_tdata[38:23]));
          compare_field("average_amplitude", 32'(want.avg), 32'(m_axis_tdata[54:39]));
          compare_field("amplitude_valid", 32'(want.amp_valid), 32'(m_axis_tuser));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("peer_presence_table regression: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      peer_key[i]     = '0;
      peer_used[i]    = 1'b0;
      peer_offline[i] = 1'b0;
      peer_age[i]     = '0;
      peer_gain[i]    = DEFAULT_GAIN;
    end
    amp_sum    = '0;
    amp_count  = '0;
    id_pool[0] = 32'h7FFF_FFFF;
    id_pool[1] = 32'h8000_0000;
    for (int i = 2; i < POOL_N; i++) id_pool[i] = $urandom();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    snd_idle_pct = 7;
    rcv_idle_pct = 60;

    send(CMD_PACKET, 32'h0, 9'h1FF, 16'hFFFF, 1'b1);
    send(CMD_PACKET, id_pool[0], 9'd0, 16'd0, 1'b0);
    send(CMD_PACKET, id_pool[1], 9'd0, 16'd0, 1'b0);
    send(CMD_PACKET, id_pool[0], 9'd0, 16'd0, 1'b0);
    send(CMD_VOLUME, id_pool[1], 9'd400, 16'd0, 1'b0);
    send(CMD_VOLUME, id_pool[2], 9'h155, 16'd0, 1'b0);
    send(CMD_SAMPLE, id_pool[2], 9'd0, 16'h1234, 1'b1);
    send(CMD_SAMPLE, id_pool[1], 9'd0, 16'h8000, 1'b0);
    send(CMD_SAMPLE, id_pool[1], 9'd0, 16'h7FFF, 1'b0);
    send(CMD_SAMPLE, id_pool[1], 9'd0, 16'hFFFF, 1'b1);
    send(CMD_VOLUME, id_pool[0], 9'h1FF, 16'd0, 1'b0);
    send(CMD_SAMPLE, id_pool[0], 9'd0, 16'd100, 1'b1);
    send(CMD_VOLUME, id_pool[0], 9'd0, 16'd0, 1'b0);
    send(CMD_SAMPLE, id_pool[0], 9'd0, 16'h8000, 1'b1);
    repeat (4) send(CMD_TICK, 32'hFFFF_FFFF, 9'h1FF, 16'hFFFF, 1'b1);
    send(CMD_PACKET, id_pool[0], 9'd0, 16'd0, 1'b0);
    send(CMD_SAMPLE, id_pool[1], 9'd0, 16'h0001, 1'b1);
    drain();

    write_reg(REG_OWN_ID, 32'h8000_0000);
    write_reg(REG_TICK_STEP, 32'd1);
    write_reg(REG_OFFLINE_LIMIT, 32'd0);
    queue_random(320);
    drain();

    snd_idle_pct = 60;
    rcv_idle_pct = 7;
    write_reg(REG_OWN_ID, 32'h7FFF_FFFF);
    write_reg(REG_TICK_STEP, 32'd65535);
    write_reg(REG_OFFLINE_LIMIT, 32'd65535);
    queue_random(320);
    drain();

    write_reg(REG_OWN_ID, $urandom());
    write_reg(REG_TICK_STEP, $urandom_range(1, 4000));
    write_reg(REG_OFFLINE_LIMIT, $urandom_range(0, 20000));
    queue_random(320);
    drain();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_reg(REG_OWN_ID, id_pool[5]);
    write_reg(REG_TICK_STEP, 32'(TICK_STEP_RST));
    write_reg(REG_OFFLINE_LIMIT, 32'(OFFLINE_LIMIT_RST));
    queue_random(320);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("peer_presence_table regression: pass");
    end else begin
      $display("peer_presence_table regression: fail");
    end
    $finish;
  end

endmodule
